// File: hdl/hpi_pkg.sv
`timescale 1ns / 1ps

package hpi_pkg;

    // Widths of the datapath
    localparam int TEMP_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 8;
    localparam int BIAS_W     = 9;
    localparam int FRAC_SHIFT = 12;
    localparam int INTEG_W    = DUTY_W + FRAC_SHIFT;    // 20
    localparam int ERR_W      = TEMP_W + 2;             // 18, holds goal + 8 - temp
    localparam int PROD_W     = GAIN_W + 1 + ERR_W;     // 35, unsigned gain times signed error
    localparam int ACC_W      = PROD_W + 1;             // 36, sums of products and small terms

    // +0.5 degC in 1/16 degC
    localparam int HALF_DEGREE = 8;

    // Configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL_TEMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_BIAS  = 3'd5;

    localparam logic [TEMP_W-1:0] GOAL_TEMP_RST  = 16'd2080;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd38400;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST   = 8'd0;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 8'd255;
    localparam logic [BIAS_W-1:0] DUTY_BIAS_RST  = 9'd0;

    typedef struct packed {
        logic [TEMP_W-1:0] goal_temp;     // signed
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [DUTY_W-1:0] duty_min;
        logic [DUTY_W-1:0] duty_max;
        logic [BIAS_W-1:0] duty_bias;     // signed
    } hpi_cfg_t;

    // min(x, max) then max(min, .), bounds scaled to 1/4096 duty steps
    function automatic logic signed [ACC_W-1:0] clamp_duty(
        input logic signed [ACC_W-1:0] x,
        input logic [DUTY_W-1:0]       lo8,
        input logic [DUTY_W-1:0]       hi8
    );
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] y;
        lo = $signed({{(ACC_W-INTEG_W){1'b0}}, lo8, {FRAC_SHIFT{1'b0}}});
        hi = $signed({{(ACC_W-INTEG_W){1'b0}}, hi8, {FRAC_SHIFT{1'b0}}});
        y  = (x > hi) ? hi : x;
        y  = (y < lo) ? lo : y;
        return y;
    endfunction

endpackage

// File: hdl/heater_pi_controller.sv
`timescale 1ns / 1ps

// PI heater controller with a clamped integrator. Each input beat is one
// control tick (temperature in 1/16 degC plus a heat enable); each tick
// gives exactly one duty beat, in order. Error is goal + 0.5 degC - temp;
// on an enabled tick the integrator (1/4096 duty steps) adds Ki * error and
// is clamped to [duty_min, duty_max], then duty = floor(clamp(Kp * error +
// integrator + bias)), saturated to 2^PWM_BITS - 1. A disabled tick gives
// duty 0 and leaves the integrator alone. Throughput is one beat per clock
// while the output is not stalled; each tick passes the error register,
// multiplier register, integrator register and output register. Every stage
// has its own valid bit and fills a bubble, so a result waiting at the
// output does not stop the stages behind it from filling. Write the
// configuration registers only while no tick is in flight.
module heater_pi_controller #(
    parameter int PWM_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tick in
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hpi_pkg::TEMP_W-1:0]      s_temp_sample,
    input  logic                           s_heat_enable,
    // duty out
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hpi_pkg::DUTY_W-1:0]      m_pwm_duty,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hpi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hpi_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hpi_pkg::*;

    hpi_cfg_t cfg;

    // gain stage -> integrator stage
    logic                     gain_valid;
    logic                     gain_ready;
    logic signed [PROD_W-1:0] kp_prod;
    logic signed [PROD_W-1:0] ki_prod;
    logic                     gain_en;

    // integrator stage -> output stage
    logic                     integ_valid;
    logic                     integ_ready;
    logic signed [ACC_W-1:0]  pterm;
    logic [INTEG_W-1:0]       integ_val;
    logic                     integ_en;

    hpi_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // error = goal + 8 - temp, then Kp and Ki products in parallel
    hpi_gain_stage u_gain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_temp     (s_temp_sample),
        .in_en       (s_heat_enable),
        .out_valid   (gain_valid),
        .out_ready   (gain_ready),
        .out_kp_prod (kp_prod),
        .out_ki_prod (ki_prod),
        .out_en      (gain_en)
    );

    // integrator update happens once per enabled beat, as it enters this stage
    hpi_integ_stage u_integ (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (gain_valid),
        .in_ready   (gain_ready),
        .in_kp_prod (kp_prod),
        .in_ki_prod (ki_prod),
        .in_en      (gain_en),
        .out_valid  (integ_valid),
        .out_ready  (integ_ready),
        .out_pterm  (pterm),
        .out_integ  (integ_val),
        .out_en     (integ_en)
    );

    // final sum, clamp, floor and resolution cap into the output register
    hpi_duty_stage #(
        .PWM_BITS (PWM_BITS)
    ) u_duty (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (integ_valid),
        .in_ready  (integ_ready),
        .in_pterm  (pterm),
        .in_integ  (integ_val),
        .in_en     (integ_en),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_duty  (m_pwm_duty)
    );

endmodule

// File: hdl/hpi_cfg_regs.sv
`timescale 1ns / 1ps

module hpi_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hpi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpi_pkg::CFG_DATA_W-1:0] cfg_data,
    output hpi_pkg::hpi_cfg_t             cfg
);
    import hpi_pkg::*;

    hpi_cfg_t cfg_reg;
    hpi_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_GOAL_TEMP:  cfg_next.goal_temp  = cfg_data[TEMP_W-1:0];
                REG_PROP_GAIN:  cfg_next.prop_gain  = cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: cfg_next.integ_gain = cfg_data[GAIN_W-1:0];
                REG_DUTY_MIN:   cfg_next.duty_min   = cfg_data[DUTY_W-1:0];
                REG_DUTY_MAX:   cfg_next.duty_max   = cfg_data[DUTY_W-1:0];
                REG_DUTY_BIAS:  cfg_next.duty_bias  = cfg_data[BIAS_W-1:0];
                default:        cfg_next = cfg_reg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_temp  <= GOAL_TEMP_RST;
            cfg_reg.prop_gain  <= PROP_GAIN_RST;
            cfg_reg.integ_gain <= INTEG_GAIN_RST;
            cfg_reg.duty_min   <= DUTY_MIN_RST;
            cfg_reg.duty_max   <= DUTY_MAX_RST;
            cfg_reg.duty_bias  <= DUTY_BIAS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/hpi_gain_stage.sv
`timescale 1ns / 1ps

module hpi_gain_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hpi_pkg::hpi_cfg_t                 cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hpi_pkg::TEMP_W-1:0]        in_temp,
    input  logic                              in_en,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hpi_pkg::PROD_W-1:0] out_kp_prod,
    output logic signed [hpi_pkg::PROD_W-1:0] out_ki_prod,
    output logic                              out_en
);
    import hpi_pkg::*;

    // step 1: error
    logic                    err_valid_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;
    logic                    err_en_reg;
    logic                    err_ready;

    // step 2: products
    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] kp_prod_reg;
    logic signed [PROD_W-1:0] ki_prod_reg;
    logic signed [PROD_W-1:0] kp_prod_next;
    logic signed [PROD_W-1:0] ki_prod_next;
    logic                     prod_en_reg;
    logic                     prod_ready;

    assign prod_ready = !prod_valid_reg || out_ready;
    assign err_ready  = !err_valid_reg || prod_ready;
    assign in_ready   = err_ready;

    assign err_next = $signed({{(ERR_W-TEMP_W){cfg.goal_temp[TEMP_W-1]}}, cfg.goal_temp})
                    + $signed(ERR_W'(HALF_DEGREE))
                    - $signed({{(ERR_W-TEMP_W){in_temp[TEMP_W-1]}}, in_temp});

    assign kp_prod_next = $signed({1'b0, cfg.prop_gain}) * err_reg;
    assign ki_prod_next = $signed({1'b0, cfg.integ_gain}) * err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (err_ready) begin
                err_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                prod_valid_reg <= err_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && err_ready) begin
            err_reg    <= err_next;
            err_en_reg <= in_en;
        end
        if (err_valid_reg && prod_ready) begin
            kp_prod_reg <= kp_prod_next;
            ki_prod_reg <= ki_prod_next;
            prod_en_reg <= err_en_reg;
        end
    end

    assign out_valid   = prod_valid_reg;
    assign out_kp_prod = kp_prod_reg;
    assign out_ki_prod = ki_prod_reg;
    assign out_en      = prod_en_reg;

endmodule

// File: hdl/hpi_integ_stage.sv
`timescale 1ns / 1ps

module hpi_integ_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hpi_pkg::hpi_cfg_t                 cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [hpi_pkg::PROD_W-1:0] in_kp_prod,
    input  logic signed [hpi_pkg::PROD_W-1:0] in_ki_prod,
    input  logic                              in_en,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hpi_pkg::ACC_W-1:0]  out_pterm,
    output logic [hpi_pkg::INTEG_W-1:0]       out_integ,
    output logic                              out_en
);
    import hpi_pkg::*;

    logic [INTEG_W-1:0]      integ_reg;
    logic [INTEG_W-1:0]      integ_next;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_clamped;
    logic signed [ACC_W-1:0] pterm_next;
    logic                    load;

    logic                    valid_reg;
    logic signed [ACC_W-1:0] pterm_reg;
    logic [INTEG_W-1:0]      integ_out_reg;
    logic                    en_reg;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign acc = $signed({{(ACC_W-PROD_W){in_ki_prod[PROD_W-1]}}, in_ki_prod})
               + $signed({{(ACC_W-INTEG_W){1'b0}}, integ_reg});
    assign acc_clamped = clamp_duty(acc, cfg.duty_min, cfg.duty_max);
    assign integ_next  = acc_clamped[INTEG_W-1:0];

    // proportional term plus bias scaled to 1/4096 duty steps
    assign pterm_next = $signed({{(ACC_W-PROD_W){in_kp_prod[PROD_W-1]}}, in_kp_prod})
                      + $signed({{(ACC_W-BIAS_W-FRAC_SHIFT){cfg.duty_bias[BIAS_W-1]}},
                                 cfg.duty_bias, {FRAC_SHIFT{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load && in_en) begin
                integ_reg <= integ_next;
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pterm_reg     <= pterm_next;
            integ_out_reg <= integ_next;
            en_reg        <= in_en;
        end
    end

    assign out_valid = valid_reg;
    assign out_pterm = pterm_reg;
    assign out_integ = integ_out_reg;
    assign out_en    = en_reg;

endmodule

// File: hdl/hpi_duty_stage.sv
`timescale 1ns / 1ps

module hpi_duty_stage #(
    parameter int PWM_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  hpi_pkg::hpi_cfg_t                cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [hpi_pkg::ACC_W-1:0] in_pterm,
    input  logic [hpi_pkg::INTEG_W-1:0]      in_integ,
    input  logic                             in_en,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [hpi_pkg::DUTY_W-1:0]       out_duty
);
    import hpi_pkg::*;

    localparam int CAP_W = 17;
    localparam logic [CAP_W-1:0] DUTY_CAP = CAP_W'((1 << PWM_BITS) - 1);

    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] sum_clamped;
    logic [DUTY_W-1:0]       duty_floor;
    logic [DUTY_W-1:0]       duty_capped;
    logic [DUTY_W-1:0]       duty_next;

    logic                    valid_reg;
    logic [DUTY_W-1:0]       duty_reg;

    assign in_ready = !valid_reg || out_ready;

    assign sum = in_pterm + $signed({{(ACC_W-INTEG_W){1'b0}}, in_integ});
    assign sum_clamped = clamp_duty(sum, cfg.duty_min, cfg.duty_max);
    // clamped sum is within [0, 255 << 12], so the slice is the floor
    assign duty_floor  = sum_clamped[INTEG_W-1:FRAC_SHIFT];
    assign duty_capped = ({{(CAP_W-DUTY_W){1'b0}}, duty_floor} > DUTY_CAP)
                       ? DUTY_CAP[DUTY_W-1:0] : duty_floor;
    assign duty_next   = in_en ? duty_capped : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            duty_reg <= duty_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_duty  = duty_reg;

endmodule

// File: hdl/hpi_checker.sv
`timescale 1ns / 1ps

module hpi_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [hpi_pkg::DUTY_W-1:0]      m_pwm_duty
);
    // beats accepted and not yet delivered; pipeline holds at most four
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign inflight_next = inflight_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pwm_duty))
        else $error("stalled output beat dropped or changed");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 3'd0)
        else $error("output beat with no tick in flight");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'd4)
        else $error("more ticks in flight than pipeline stages");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == 3'd0 |-> s_ready)
        else $error("empty pipeline refuses input");

endmodule

bind heater_pi_controller hpi_checker u_hpi_checker (.*);

// File: bench/heater_pi_controller_tb.sv
`timescale 1ns / 1ps

// Checks the PI heater controller against its own cycle-free model of the
// loop. A negedge driver feeds ticks from a queue in bursts; a negedge
// receiver throttles the duty channel; the posedge monitor predicts each
// duty at the moment its tick is accepted and checks duty beats in order.
module heater_pi_controller_tb;

    import hpi_pkg::*;

    localparam int PWM_BITS = 8;

    // Indexes outside the register map; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [TEMP_W-1:0] temp;
        logic              heat_on;
    } heat_tick_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [TEMP_W-1:0]     s_temp_sample;
    logic                  s_heat_enable;
    logic                  m_valid;
    logic                  m_ready;
    logic [DUTY_W-1:0]     m_pwm_duty;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    heater_pi_controller #(
        .PWM_BITS (PWM_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temp_sample (s_temp_sample),
        .s_heat_enable (s_heat_enable),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pwm_duty    (m_pwm_duty),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Ticks waiting to be driven, and duties the block still owes us.
    heat_tick_t        tick_q[$];
    logic [DUTY_W-1:0] duty_q[$];

    // Loop model: shadow registers plus the integrator, 1/4096 duty steps.
    logic [TEMP_W-1:0]  goal_r;
    logic [GAIN_W-1:0]  kp_r;
    logic [GAIN_W-1:0]  ki_r;
    logic [DUTY_W-1:0]  dmin_r;
    logic [DUTY_W-1:0]  dmax_r;
    logic [BIAS_W-1:0]  bias_r;
    logic [INTEG_W-1:0] integ_r;

    int n_ticks_in;
    int n_ticks_off;
    int n_duty_out;
    int n_in_stalls;
    int n_settings;
    int n_errors;

    // Handshake flag passed from the posedge monitor to the negedge driver.
    logic              tick_taken;
    heat_tick_t        drive_tick;
    int                burst_left;
    int                gap_left;
    logic [DUTY_W-1:0] want_duty;

    // Receiver pacing state.
    rx_mode_t rx_mode;
    int       mode_left;
    int       hold_left;
    logic     hold_done;

    //------------------------------------------------------------------------
    // Loop model
    //------------------------------------------------------------------------

    // Upper bound first, then lower: min above max collapses to min.
    function automatic longint limit_to(input longint x, input longint lo, input longint hi);
        longint y;
        y = (x > hi) ? hi : x;
        y = (y < lo) ? lo : y;
        return y;
    endfunction

    // One control tick. Updates integ_r on an enabled tick only.
    function automatic logic [DUTY_W-1:0] step_heat_loop(input logic [TEMP_W-1:0] temp,
                                                          input logic heat_on);
        longint lo;
        longint hi;
        longint err;
        longint acc;
        longint duty;
        longint cap;
        lo   = longint'(dmin_r) <<< FRAC_SHIFT;
        hi   = longint'(dmax_r) <<< FRAC_SHIFT;
        err  = longint'($signed(goal_r)) + HALF_DEGREE - longint'($signed(temp));
        cap  = (longint'(1) <<< PWM_BITS) - 1;
        if (!heat_on)
            return '0;
        // integrator is only clamped here, so after reset it may sit below min
        acc     = longint'(integ_r) + longint'(ki_r) * err;
        acc     = limit_to(acc, lo, hi);
        integ_r = acc[INTEG_W-1:0];
        acc  = longint'(kp_r) * err + longint'(integ_r)
             + longint'($signed(bias_r)) * (longint'(1) <<< FRAC_SHIFT);
        acc  = limit_to(acc, lo, hi);
        duty = acc >>> FRAC_SHIFT;    // acc >= 0 here, so this is a floor
        if (duty > cap)
            duty = cap;
        return duty[DUTY_W-1:0];
    endfunction

    //------------------------------------------------------------------------
    // Clock
    //------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    //------------------------------------------------------------------------
    // Monitor: sample both channels and the register port at the rising edge
    //------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            tick_taken = 1'b0;
            goal_r     = GOAL_TEMP_RST;
            kp_r       = PROP_GAIN_RST;
            ki_r       = INTEG_GAIN_RST;
            dmin_r     = DUTY_MIN_RST;
            dmax_r     = DUTY_MAX_RST;
            bias_r     = DUTY_BIAS_RST;
            integ_r    = '0;
        end else begin
            tick_taken = s_valid && s_ready;
            if (s_valid && !s_ready)
                n_in_stalls++;

            // Duty beat out: check first, the pipe is several stages deep.
            if (m_valid && m_ready) begin
                n_duty_out++;
                if (duty_q.size() == 0) begin
                    $display("%0t ns: unexpected duty beat, expected none, got %0d",
                             $time, m_pwm_duty);
                    n_errors++;
                end else begin
                    want_duty = duty_q.pop_front();
                    if (m_pwm_duty !== want_duty) begin
                        $display("%0t ns: pwm_duty mismatch, expected %0d, got %0d",
                                 $time, want_duty, m_pwm_duty);
                        n_errors++;
                    end
                end
            end

            // Tick beat in: predict with the registers in force right now.
            if (tick_taken) begin
                duty_q.push_back(step_heat_loop(s_temp_sample, s_heat_enable));
                n_ticks_in++;
                if (!s_heat_enable)
                    n_ticks_off++;
            end

            // Register write beat. Only lands while no tick is in flight.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GOAL_TEMP:  goal_r = cfg_data[TEMP_W-1:0];
                    REG_PROP_GAIN:  kp_r   = cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN: ki_r   = cfg_data[GAIN_W-1:0];
                    REG_DUTY_MIN:   dmin_r = cfg_data[DUTY_W-1:0];
                    REG_DUTY_MAX:   dmax_r = cfg_data[DUTY_W-1:0];
                    REG_DUTY_BIAS:  bias_r = cfg_data[BIAS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    //------------------------------------------------------------------------
    // Tick driver: bursts of random length, random gaps (often none).
    // Holds valid and payload until the beat is taken.
    //------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || tick_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                drive_tick = tick_q.pop_front();
                s_valid       <= 1'b1;
                s_temp_sample <= drive_tick.temp;
                s_heat_enable <= drive_tick.heat_on;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    //------------------------------------------------------------------------
    // Duty receiver: switches at random between pacing modes.
    // Once, early in the random part, it stops taking beats for a long
    // stretch so the pipe fills and s_ready has to drop.
    //------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && n_ticks_in >= 40) begin
            hold_done = 1'b1;
            hold_left = 150;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 64);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_HALF:   m_ready <= $urandom_range(0, 1);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ~m_ready;
            endcase
        end
    end

    //------------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------------
    task automatic add_tick(input logic [TEMP_W-1:0] temp, input logic heat_on);
        heat_tick_t tk;
        tk.temp    = temp;
        tk.heat_on = heat_on;
        tick_q.push_back(tk);
    endtask

    // Leaves cfg_valid high so back-to-back writes never drop it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // All six registers; junk in the unused upper data bits of narrow ones.
    task automatic apply_setting(input logic [TEMP_W-1:0] goal,
                                 input logic [GAIN_W-1:0] kp,
                                 input logic [GAIN_W-1:0] ki,
                                 input logic [DUTY_W-1:0] dmin,
                                 input logic [DUTY_W-1:0] dmax,
                                 input logic [BIAS_W-1:0] bias);
        write_reg(REG_GOAL_TEMP,  goal);
        write_reg(REG_PROP_GAIN,  kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DUTY_MIN,   {8'($urandom), dmin});
        write_reg(REG_DUTY_MAX,   {8'($urandom), dmax});
        write_reg(REG_DUTY_BIAS,  {7'($urandom), bias});
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        n_settings++;
    endtask

    // Every tick gives a duty, so an empty duty queue means an empty pipe.
    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (tick_q.size() != 0 || s_valid || duty_q.size() != 0);
    endtask

    //------------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------------
    initial begin
        logic [TEMP_W-1:0] goal;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [DUTY_W-1:0] lo8;
        logic [DUTY_W-1:0] hi8;
        logic [DUTY_W-1:0] swap8;
        int                t;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_temp_sample = '0;
        s_heat_enable = 1'b0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_GOAL_TEMP;
        cfg_data      = '0;
        tick_taken    = 1'b0;
        burst_left    = 1;
        gap_left      = 0;
        rx_mode       = RX_ALWAYS;
        mode_left     = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        n_ticks_in    = 0;
        n_ticks_off   = 0;
        n_duty_out    = 0;
        n_in_stalls   = 0;
        n_settings    = 0;
        n_errors      = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: zero error, target itself, both temp extremes,
        // a disabled tick, and two enabled ones below target.
        add_tick(16'd2088, 1'b1);
        add_tick(16'd2080, 1'b1);
        add_tick(16'h8000, 1'b1);
        add_tick(16'h7FFF, 1'b1);
        add_tick(16'd0,    1'b0);
        add_tick(16'd0,    1'b1);
        add_tick(16'd2000, 1'b1);
        wait_idle();

        // Integrator still at zero, now below a raised min: holds through a
        // disabled tick, then snaps up to min on the first enabled one.
        apply_setting(16'd2080, 16'd0, 16'd0, 8'd100, 8'd200, 9'd0);
        add_tick(16'd2088, 1'b0);
        add_tick(16'd2088, 1'b1);
        add_tick(16'd2000, 1'b1);
        wait_idle();

        // Min above max, bias at the out-of-range code -256.
        apply_setting(16'd0, 16'd256, 16'd4096, 8'd200, 8'd10, 9'h100);
        add_tick(16'd8,    1'b1);
        add_tick(16'h8000, 1'b1);
        add_tick(16'h7FFF, 1'b1);
        add_tick(16'd100,  1'b0);
        wait_idle();

        // Largest gains, lowest target, largest bias.
        apply_setting(16'h8000, 16'hFFFF, 16'hFFFF, 8'd0, 8'd255, 9'd255);
        add_tick(16'h7FFF, 1'b1);
        add_tick(16'h8000, 1'b1);
        add_tick(16'h8008, 1'b1);
        wait_idle();

        // Highest target, zero-width clamp window, most negative legal bias.
        apply_setting(16'h7FFF, 16'hFFFF, 16'd1, 8'd0, 8'd0, 9'h101);
        add_tick(16'h8000, 1'b1);
        add_tick(16'h7FFF, 1'b1);
        wait_idle();

        // Random part: eight settings, 75 ticks each. Most ticks sit within
        // a few degrees of target so the loop runs unsaturated and the
        // integrator wanders; the rest span the whole sample range.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                // unmapped indexes, must be ignored
                write_reg(REG_SPARE_LO, 16'($urandom));
                write_reg(REG_SPARE_HI, 16'($urandom));
            end
            if ($urandom_range(0, 3) != 0)
                goal = 16'($urandom_range(0, 4800) - 800);
            else
                goal = 16'($urandom);
            case ($urandom_range(0, 3))
                0:       kp = 16'($urandom);
                1:       kp = 16'($urandom_range(0, 512));
                2:       kp = 16'($urandom_range(0, 4096));
                default: kp = PROP_GAIN_RST;
            endcase
            case ($urandom_range(0, 3))
                0:       ki = 16'($urandom_range(0, 64));
                1:       ki = 16'($urandom_range(0, 1024));
                2:       ki = 16'($urandom);
                default: ki = INTEG_GAIN_RST;
            endcase
            lo8 = 8'($urandom);
            hi8 = 8'($urandom);
            if (lo8 > hi8 && $urandom_range(0, 4) != 0) begin
                swap8 = lo8;
                lo8   = hi8;
                hi8   = swap8;
            end
            apply_setting(goal, kp, ki, lo8, hi8, 9'($urandom));

            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(0, 3) != 0)
                    t = int'($signed(goal)) + HALF_DEGREE + int'($urandom_range(0, 96)) - 48;
                else
                    t = int'($urandom);
                add_tick(t[TEMP_W-1:0], $urandom_range(0, 6) != 0);
            end
            wait_idle();
        end

        // Pipe is empty; give a stray beat a chance to show up.
        repeat (20) @(posedge aclk);
        #1;
        if (duty_q.size() != 0) begin
            $display("%0t ns: %0d duty beats never arrived", $time, duty_q.size());
            n_errors++;
        end

        $display("Ran %0d ticks (%0d with heat off) over %0d register settings, %0d duty beats",
                 n_ticks_in, n_ticks_off, n_settings, n_duty_out);
        $display("Input side stalled for %0d cycles under output backpressure, %0d errors",
                 n_in_stalls, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("%0t ns: timeout, %0d duty beats still owed", $time, duty_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
